// File: hdl/chip8_instruction_executor_unit_defines.svh
// Assertion macros shared by the executor RTL files.
`ifndef CHIP8_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low
`define C8X_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while aresetn is low
`define C8X_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/c8x_pkg.sv
// Shared types, opcode codes and sizes of the CHIP-8 executor.
`timescale 1ns / 1ps
`default_nettype none

package c8x_pkg;

    // Sizes
    localparam int INSTR_W     = 16;
    localparam int ADDR_W      = 12;
    localparam int DATA_W      = 8;
    localparam int NUM_REGS    = 16;
    localparam int REG_IDX_W   = 4;
    localparam int STACK_DEPTH = 16;
    localparam int STACK_LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int STACK_IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Counter value after reset
    localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;

    // Top nibble of the instruction word
    typedef enum logic [3:0] {
        GRP_SYS      = 4'h0,
        GRP_JP       = 4'h1,
        GRP_CALL     = 4'h2,
        GRP_SE_BYTE  = 4'h3,
        GRP_SNE_BYTE = 4'h4,
        GRP_SE_REG   = 4'h5,
        GRP_LD_BYTE  = 4'h6,
        GRP_ADD_BYTE = 4'h7,
        GRP_ALU      = 4'h8,
        GRP_SNE_REG  = 4'h9,
        GRP_LD_I     = 4'hA,
        GRP_JP_V0    = 4'hB,
        GRP_RND      = 4'hC,
        GRP_DRW      = 4'hD,
        GRP_KEY      = 4'hE,
        GRP_MISC     = 4'hF
    } group_t;

    // Full-word and low-byte codes
    localparam logic [INSTR_W-1:0] OP_RET = 16'h00EE;

    localparam logic [7:0] EX_SKP      = 8'h9E;
    localparam logic [7:0] EX_SKNP     = 8'hA1;
    localparam logic [7:0] FX_LD_VX_DT = 8'h07;
    localparam logic [7:0] FX_LD_KEY   = 8'h0A;
    localparam logic [7:0] FX_LD_DT    = 8'h15;
    localparam logic [7:0] FX_LD_ST    = 8'h18;
    localparam logic [7:0] FX_ADD_I    = 8'h1E;
    localparam logic [7:0] FX_LD_F     = 8'h29;
    localparam logic [7:0] FX_LD_B     = 8'h33;
    localparam logic [7:0] FX_LD_MEM   = 8'h55;
    localparam logic [7:0] FX_LD_REGS  = 8'h65;

    typedef enum logic [1:0] {
        ST_EXEC    = 2'd0,
        ST_NOP     = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_FAULT   = 2'd3
    } status_t;

    // One result, first field in the high bits
    typedef struct packed {
        status_t                 status;
        logic [DATA_W-1:0]       reg_value;
        logic [REG_IDX_W-1:0]    reg_number;
        logic                    reg_written;
        logic [DATA_W-1:0]       sound_value;
        logic [DATA_W-1:0]       delay_value;
        logic [ADDR_W-1:0]       index_value;
        logic [ADDR_W-1:0]       next_pc;
    } result_t;

    localparam int RESULT_W   = $bits(result_t);
    localparam int M_TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    // Register file read request for the instruction entering the input register
    typedef struct packed {
        logic [REG_IDX_W-1:0] x;
        logic [REG_IDX_W-1:0] y;
    } rd_req_t;

endpackage

`default_nettype wire

// File: hdl/chip8_instruction_executor_unit.sv
// Top level of the CHIP-8 instruction executor: input and result registers.
//
// Channel   Dir  Fields (tdata, low bit first)
// s_        in   instruction[15:0]
// m_        out  next_pc, index_value, delay_value, sound_value, reg_written,
//                reg_number, reg_value, status, one zero pad bit
// cfg_      in   program_start[11:0] (write only)
//
// One instruction per cycle sustained while m_tready stays high; an input request
// passes the input register, then is executed into the result register.
// The result register holds a request while m_tready is low; the input register
// keeps taking one more request, then s_tready drops until the result moves.
// Synchronous active-low reset: counter to 0x200, registers, timers and stack empty.
// No clearing pass after reset; a write of program_start also loads the counter.
`timescale 1ns / 1ps
`default_nettype none
`include "chip8_instruction_executor_unit_defines.svh"

module chip8_instruction_executor_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // instruction[15:0]
    input  wire logic [c8x_pkg::INSTR_W-1:0]    s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // next_pc[11:0], index_value[23:12], delay_value[31:24], sound_value[39:32],
    // reg_written[40], reg_number[44:41], reg_value[52:45], status[54:53], pad[55]
    output logic [c8x_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_we,
    input  wire logic [c8x_pkg::ADDR_W-1:0]     cfg_wdata
);

    logic                          instr_valid_reg;
    logic [c8x_pkg::INSTR_W-1:0]   instr_reg;
    logic                          m_tvalid_reg;
    logic [c8x_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                          s_accept;
    logic                          exec_fire;
    logic [c8x_pkg::INSTR_W-1:0]   instr_next;
    c8x_pkg::rd_req_t              rd_req;
    c8x_pkg::result_t              res;

    // Handshake
    assign exec_fire = instr_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !instr_valid_reg || exec_fire;
    assign s_accept  = s_tvalid && s_tready;

    // Register reads target whatever sits in the input register next cycle
    assign instr_next = s_accept ? s_tdata : instr_reg;
    assign rd_req.x   = instr_next[11:8];
    assign rd_req.y   = instr_next[7:4];

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            instr_valid_reg <= 1'b0;
        end else if (s_accept) begin
            instr_valid_reg <= 1'b1;
        end else if (exec_fire) begin
            instr_valid_reg <= 1'b0;
        end
        if (s_accept) begin
            instr_reg <= s_tdata;
        end
    end

    c8x_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .exec_en   (exec_fire),
        .instr     (instr_reg),
        .rd_req    (rd_req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .res       (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (exec_fire) begin
            m_tdata_reg <= c8x_pkg::M_TDATA_W'(res);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `C8X_ASSERT_IMP(a_no_overwrite, m_tvalid_reg && !m_tready, !exec_fire, "result overwritten while stalled")
    `C8X_ASSERT_NXT(a_accept_fills, s_accept, instr_valid_reg, "accepted request not held")
    `C8X_ASSERT_NXT(a_exec_shows, exec_fire, m_tvalid_reg, "executed request not presented")

endmodule

`default_nettype wire

// File: hdl/c8x_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read (read returns old data on collision)
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/c8x_core.sv
// Architectural state and combinational execute logic of the executor.
`timescale 1ns / 1ps
`default_nettype none
`include "chip8_instruction_executor_unit_defines.svh"

module c8x_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         exec_en,
    input  wire logic [c8x_pkg::INSTR_W-1:0]  instr,
    input  wire c8x_pkg::rd_req_t             rd_req,
    input  wire logic                         cfg_we,
    input  wire logic [c8x_pkg::ADDR_W-1:0]   cfg_wdata,
    output c8x_pkg::result_t                  res
);

    // Architectural state
    logic [c8x_pkg::ADDR_W-1:0]      pc_reg;
    logic [c8x_pkg::ADDR_W-1:0]      index_reg;
    logic [c8x_pkg::DATA_W-1:0]      delay_reg;
    logic [c8x_pkg::DATA_W-1:0]      sound_reg;
    logic [c8x_pkg::DATA_W-1:0]      v0_reg;
    logic [c8x_pkg::STACK_LVL_W-1:0] stack_level_reg;
    logic [c8x_pkg::ADDR_W-1:0]      stack_reg [c8x_pkg::STACK_DEPTH];
    logic [c8x_pkg::NUM_REGS-1:0]    reg_valid_reg;

    // Register file read side
    logic                        x_valid_reg, y_valid_reg;
    logic                        x_byp_reg, y_byp_reg;
    logic [c8x_pkg::DATA_W-1:0]  byp_val_reg;
    logic [c8x_pkg::DATA_W-1:0]  ram_x_q, ram_y_q;
    logic [c8x_pkg::DATA_W-1:0]  vx, vy;

    // Decode
    c8x_pkg::group_t                group;
    logic [c8x_pkg::ADDR_W-1:0]     nnn;
    logic [c8x_pkg::REG_IDX_W-1:0]  x_idx;
    logic [c8x_pkg::DATA_W-1:0]     kk;

    // Execute results
    logic [c8x_pkg::ADDR_W-1:0]      pc_seq, pc_skip, pc_next;
    logic [c8x_pkg::ADDR_W-1:0]      index_next;
    logic [c8x_pkg::DATA_W-1:0]      delay_next, sound_next;
    logic                            wr;
    logic [c8x_pkg::REG_IDX_W-1:0]   wnum;
    logic [c8x_pkg::DATA_W-1:0]      wval;
    c8x_pkg::status_t                status;
    logic                            push, pop;
    logic                            wr_fire;
    logic [c8x_pkg::STACK_LVL_W-1:0] pop_level;
    logic [c8x_pkg::STACK_IDX_W-1:0] push_idx, pop_idx;

    assign group = c8x_pkg::group_t'(instr[15:12]);
    assign nnn   = instr[11:0];
    assign x_idx = instr[11:8];
    assign kk    = instr[7:0];

    assign pc_seq    = pc_reg + 12'd2;
    assign pc_skip   = pc_reg + 12'd4;
    assign pop_level = stack_level_reg - c8x_pkg::STACK_LVL_W'(1);
    assign push_idx  = stack_level_reg[c8x_pkg::STACK_IDX_W-1:0];
    assign pop_idx   = pop_level[c8x_pkg::STACK_IDX_W-1:0];
    assign wr_fire   = exec_en && wr;

    // General register copies, one per read port
    c8x_ram #(
        .WIDTH (c8x_pkg::DATA_W),
        .DEPTH (c8x_pkg::NUM_REGS)
    ) u_ram_x (
        .aclk  (aclk),
        .we    (wr_fire),
        .waddr (wnum),
        .wdata (wval),
        .raddr (rd_req.x),
        .rdata (ram_x_q)
    );

    c8x_ram #(
        .WIDTH (c8x_pkg::DATA_W),
        .DEPTH (c8x_pkg::NUM_REGS)
    ) u_ram_y (
        .aclk  (aclk),
        .we    (wr_fire),
        .waddr (wnum),
        .wdata (wval),
        .raddr (rd_req.y),
        .rdata (ram_y_q)
    );

    // Read qualifiers: unwritten registers read zero, same-edge write is forwarded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg <= 1'b0;
            y_valid_reg <= 1'b0;
            x_byp_reg   <= 1'b0;
            y_byp_reg   <= 1'b0;
        end else begin
            x_valid_reg <= reg_valid_reg[rd_req.x];
            y_valid_reg <= reg_valid_reg[rd_req.y];
            x_byp_reg   <= wr_fire && (wnum == rd_req.x);
            y_byp_reg   <= wr_fire && (wnum == rd_req.y);
        end
        byp_val_reg <= wval;
    end

    assign vx = x_byp_reg ? byp_val_reg : (x_valid_reg ? ram_x_q : '0);
    assign vy = y_byp_reg ? byp_val_reg : (y_valid_reg ? ram_y_q : '0);

    // Execute
    always_comb begin
        pc_next    = pc_seq;
        index_next = index_reg;
        delay_next = delay_reg;
        sound_next = sound_reg;
        wr         = 1'b0;
        wnum       = '0;
        wval       = '0;
        status     = c8x_pkg::ST_EXEC;
        push       = 1'b0;
        pop        = 1'b0;
        case (group)
            c8x_pkg::GRP_SYS: begin
                if (instr == c8x_pkg::OP_RET) begin
                    if (stack_level_reg == '0) begin
                        status = c8x_pkg::ST_FAULT;
                    end else begin
                        pop     = 1'b1;
                        pc_next = stack_reg[pop_idx];
                    end
                end else begin
                    status = c8x_pkg::ST_NOP;
                end
            end
            c8x_pkg::GRP_JP: begin
                pc_next = nnn;
            end
            c8x_pkg::GRP_CALL: begin
                if (stack_level_reg >= c8x_pkg::STACK_LVL_W'(c8x_pkg::STACK_DEPTH)) begin
                    status = c8x_pkg::ST_FAULT;
                end else begin
                    push    = 1'b1;
                    pc_next = nnn;
                end
            end
            c8x_pkg::GRP_SE_BYTE: begin
                if (vx == kk) pc_next = pc_skip;
            end
            c8x_pkg::GRP_SNE_BYTE: begin
                if (vx != kk) pc_next = pc_skip;
            end
            c8x_pkg::GRP_SE_REG: begin
                if (vx == vy) pc_next = pc_skip;
            end
            c8x_pkg::GRP_LD_BYTE: begin
                wr   = 1'b1;
                wnum = x_idx;
                wval = kk;
            end
            c8x_pkg::GRP_ADD_BYTE: begin
                wr   = 1'b1;
                wnum = x_idx;
                wval = vx + kk;
            end
            c8x_pkg::GRP_SNE_REG: begin
                if (vx != vy) pc_next = pc_skip;
            end
            c8x_pkg::GRP_LD_I: begin
                index_next = nnn;
            end
            c8x_pkg::GRP_JP_V0: begin
                pc_next = {4'h0, v0_reg} + nnn;
            end
            c8x_pkg::GRP_KEY: begin
                if (kk inside {c8x_pkg::EX_SKP, c8x_pkg::EX_SKNP}) begin
                    status = c8x_pkg::ST_NOP;
                end else begin
                    status = c8x_pkg::ST_UNKNOWN;
                end
            end
            c8x_pkg::GRP_MISC: begin
                case (kk)
                    c8x_pkg::FX_LD_VX_DT: begin
                        wr   = 1'b1;
                        wnum = x_idx;
                        wval = delay_reg;
                    end
                    c8x_pkg::FX_LD_DT: delay_next = vx;
                    c8x_pkg::FX_LD_ST: sound_next = vx;
                    default: begin
                        if (kk inside {c8x_pkg::FX_LD_KEY, c8x_pkg::FX_ADD_I,
                                       c8x_pkg::FX_LD_F, c8x_pkg::FX_LD_B,
                                       c8x_pkg::FX_LD_MEM, c8x_pkg::FX_LD_REGS}) begin
                            status = c8x_pkg::ST_NOP;
                        end else begin
                            status = c8x_pkg::ST_UNKNOWN;
                        end
                    end
                endcase
            end
            // ALU, random and draw groups
            default: begin
                status = c8x_pkg::ST_NOP;
            end
        endcase
    end

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg          <= c8x_pkg::PC_RESET;
            index_reg       <= '0;
            delay_reg       <= '0;
            sound_reg       <= '0;
            v0_reg          <= '0;
            stack_level_reg <= '0;
            reg_valid_reg   <= '0;
        end else if (cfg_we) begin
            pc_reg <= cfg_wdata;
        end else if (exec_en) begin
            pc_reg    <= pc_next;
            index_reg <= index_next;
            delay_reg <= delay_next;
            sound_reg <= sound_next;
            if (wr) begin
                reg_valid_reg[wnum] <= 1'b1;
                if (wnum == '0) v0_reg <= wval;
            end
            if (push) begin
                stack_level_reg <= stack_level_reg + c8x_pkg::STACK_LVL_W'(1);
            end else if (pop) begin
                stack_level_reg <= pop_level;
            end
        end
    end

    // Return stack entries (no reset, read only after a push)
    always_ff @(posedge aclk) begin
        if (exec_en && push) begin
            stack_reg[push_idx] <= pc_seq;
        end
    end

    // Result of the instruction now executing
    always_comb begin
        res.next_pc     = pc_next;
        res.index_value = index_next;
        res.delay_value = delay_next;
        res.sound_value = sound_next;
        res.reg_written = wr;
        res.reg_number  = wnum;
        res.reg_value   = wval;
        res.status      = status;
    end

    `C8X_ASSERT_IMP(a_stack_bound, 1'b1, stack_level_reg <= c8x_pkg::STACK_LVL_W'(c8x_pkg::STACK_DEPTH), "stack level beyond depth")
    `C8X_ASSERT_NXT(a_fault_keeps_stack, exec_en && (status == c8x_pkg::ST_FAULT), $stable(stack_level_reg), "stack fault moved the stack")
    `C8X_ASSERT_IMP(a_write_only_exec, wr, status == c8x_pkg::ST_EXEC, "register write on a no-op")
    `C8X_ASSERT_IMP(a_push_pop_excl, 1'b1, !(push && pop), "push and pop together")

endmodule

`default_nettype wire

// File: dv/chip8_instruction_executor_unit_tb.sv
// Self-checking testbench for the CHIP-8 instruction executor: predicts every result.
`timescale 1ns / 1ps

module chip8_instruction_executor_unit_tb;
    import c8x_pkg::*;

    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 500000;

    // One outstanding request: the instruction and the result it must produce
    typedef struct packed {
        logic [INSTR_W-1:0] word;
        result_t            res;
    } pending_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic [INSTR_W-1:0]     s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   cfg_we;
    logic [ADDR_W-1:0]      cfg_wdata;

    // Predicted machine state
    logic [DATA_W-1:0]      cpu_v [NUM_REGS];
    logic [ADDR_W-1:0]      cpu_pc;
    logic [ADDR_W-1:0]      cpu_i;
    logic [DATA_W-1:0]      cpu_dt;
    logic [DATA_W-1:0]      cpu_snd;
    logic [ADDR_W-1:0]      call_stack [STACK_DEPTH];
    int                     call_depth;

    pending_t               pending_results [$];
    int                     mismatch_count = 0;
    int                     items_sent = 0;
    int                     cycle_count = 0;
    bit                     src_gaps_on = 1'b1;
    bit                     sink_stalls_on = 1'b1;
    int                     hold_request = 0;

    chip8_instruction_executor_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic reset_model();
        foreach (cpu_v[r]) cpu_v[r] = '0;
        foreach (call_stack[e]) call_stack[e] = '0;
        cpu_pc     = PC_RESET;
        cpu_i      = '0;
        cpu_dt     = '0;
        cpu_snd    = '0;
        call_depth = 0;
    endtask

    // Executes one instruction on the predicted state and returns its result
    function automatic result_t execute_instr(input logic [INSTR_W-1:0] word);
        result_t            r;
        logic [3:0]         x;
        logic [3:0]         y;
        logic [7:0]         kk;
        logic [ADDR_W-1:0]  nnn;
        logic [ADDR_W-1:0]  seq_pc;
        logic [ADDR_W-1:0]  skip_pc;
        x       = word[11:8];
        y       = word[7:4];
        kk      = word[7:0];
        nnn     = word[11:0];
        seq_pc  = cpu_pc + 12'd2;
        skip_pc = cpu_pc + 12'd4;
        r         = '0;
        r.status  = ST_EXEC;
        r.next_pc = seq_pc;
        case (group_t'(word[15:12]))
            GRP_SYS: begin
                if (word != OP_RET) begin
                    r.status = ST_NOP;
                end else if (call_depth == 0) begin
                    r.status = ST_FAULT;
                end else begin
                    call_depth--;
                    r.next_pc = call_stack[call_depth];
                end
            end
            GRP_JP: r.next_pc = nnn;
            GRP_CALL: begin
                if (call_depth >= STACK_DEPTH) begin
                    r.status = ST_FAULT;
                end else begin
                    call_stack[call_depth] = seq_pc;
                    call_depth++;
                    r.next_pc = nnn;
                end
            end
            GRP_SE_BYTE:  if (cpu_v[x] == kk) r.next_pc = skip_pc;
            GRP_SNE_BYTE: if (cpu_v[x] != kk) r.next_pc = skip_pc;
            GRP_SE_REG:   if (cpu_v[x] == cpu_v[y]) r.next_pc = skip_pc;
            GRP_SNE_REG:  if (cpu_v[x] != cpu_v[y]) r.next_pc = skip_pc;
            GRP_LD_BYTE: begin
                r.reg_written = 1'b1;
                r.reg_number  = x;
                r.reg_value   = kk;
            end
            GRP_ADD_BYTE: begin
                r.reg_written = 1'b1;
                r.reg_number  = x;
                r.reg_value   = cpu_v[x] + kk;
            end
            GRP_LD_I:  cpu_i = nnn;
            GRP_JP_V0: r.next_pc = nnn + {4'h0, cpu_v[0]};
            GRP_KEY:   r.status = (kk == EX_SKP || kk == EX_SKNP) ? ST_NOP : ST_UNKNOWN;
            GRP_MISC: begin
                case (kk)
                    FX_LD_VX_DT: begin
                        r.reg_written = 1'b1;
                        r.reg_number  = x;
                        r.reg_value   = cpu_dt;
                    end
                    FX_LD_DT: cpu_dt  = cpu_v[x];
                    FX_LD_ST: cpu_snd = cpu_v[x];
                    FX_LD_KEY, FX_ADD_I, FX_LD_F, FX_LD_B, FX_LD_MEM, FX_LD_REGS:
                        r.status = ST_NOP;
                    default: r.status = ST_UNKNOWN;
                endcase
            end
            // ALU, random and draw groups are not executed
            default: r.status = ST_NOP;
        endcase
        if (r.reg_written) cpu_v[r.reg_number] = r.reg_value;
        cpu_pc        = r.next_pc;
        r.index_value = cpu_i;
        r.delay_value = cpu_dt;
        r.sound_value = cpu_snd;
        return r;
    endfunction

    // Random instruction, biased so that skips, register compares and timer ops get hit
    function automatic logic [INSTR_W-1:0] random_instr();
        logic [3:0] grp;
        logic [3:0] x;
        logic [3:0] y;
        logic [7:0] kk;
        grp = 4'($urandom_range(0, 15));
        x   = 4'($urandom);
        y   = 4'($urandom);
        kk  = 8'($urandom);
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        case (group_t'(grp))
            GRP_SYS: begin
                case ($urandom_range(0, 3))
                    0, 1: return OP_RET;
                    2: return 16'h00E0;
                    default: ;
                endcase
            end
            GRP_SE_BYTE, GRP_SNE_BYTE: if ($urandom_range(0, 1) == 0) kk = cpu_v[x];
            GRP_SE_REG, GRP_SNE_REG:   if ($urandom_range(0, 2) == 0) y = x;
            GRP_LD_BYTE:               if ($urandom_range(0, 2) == 0) kk = 8'($urandom_range(0, 3));
            GRP_KEY: begin
                case ($urandom_range(0, 2))
                    0: kk = EX_SKP;
                    1: kk = EX_SKNP;
                    default: ;
                endcase
            end
            GRP_MISC: begin
                case ($urandom_range(0, 11))
                    0: kk = FX_LD_VX_DT;
                    1: kk = FX_LD_DT;
                    2: kk = FX_LD_ST;
                    3: kk = FX_LD_KEY;
                    4: kk = FX_ADD_I;
                    5: kk = FX_LD_F;
                    6: kk = FX_LD_B;
                    7: kk = FX_LD_MEM;
                    8: kk = FX_LD_REGS;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return {grp, x, y, kk};
    endfunction

    // Sends one request, predicting its result at acceptance
    task automatic send_instr(input logic [INSTR_W-1:0] word);
        pending_t p;
        if (src_gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tdata  = word;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p.word = word;
        p.res  = execute_instr(word);
        pending_results.push_back(p);
        items_sent++;
        @(negedge aclk);
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (LATENCY + 2) @(negedge aclk);
    endtask

    task automatic write_program_start(input logic [ADDR_W-1:0] addr);
        cfg_wdata = addr;
        cfg_we    = 1'b1;
        @(negedge aclk);
        cfg_we    = 1'b0;
        cpu_pc    = addr;
    endtask

    // Nested calls then the matching returns; deep ones overflow and underflow
    task automatic send_call_burst(input int levels);
        for (int n = 0; n < levels; n++) begin
            send_instr({GRP_CALL, 12'($urandom)});
            if ($urandom_range(0, 2) == 0) send_instr(random_instr());
        end
        repeat (levels) send_instr(OP_RET);
    endtask

    task automatic report_mismatch(input string what, input logic [INSTR_W-1:0] word,
                                   input logic [15:0] got, input logic [15:0] want);
        mismatch_count++;
        $display("%0t mismatch %s: instr %h got %h want %h", $realtime, what, word, got,
                 want);
    endtask

    task automatic check_field(input string what, input logic [INSTR_W-1:0] word,
                               input logic [15:0] got, input logic [15:0] want);
        if (got !== want) report_mismatch(what, word, got, want);
    endtask

    // Extremes of the fields, every operation and the no-op/unknown/fault cases
    task automatic test_reset_values();
        logic [INSTR_W-1:0] prog [25] = '{
            16'h60FF, 16'h7001, 16'h6FFF, 16'h3000, 16'h4F00,
            16'h50F1, 16'h90FF, 16'hAFFF, 16'hBFFF, 16'h1FFE,
            16'h2ABC, 16'h00EE, 16'h00EE, 16'hFF15, 16'hFF18,
            16'hF307, 16'h00E0, 16'h0123, 16'h8FFF, 16'hC000,
            16'hDFFF, 16'hE19E, 16'hEFA1, 16'hE0FF, 16'hFFFF
        };
        foreach (prog[k]) send_instr(prog[k]);
    endtask

    // Several start addresses, extremes included, each followed by random code
    task automatic test_program_start();
        logic [ADDR_W-1:0] starts [4];
        starts = '{12'hFFF, 12'h000, 12'($urandom), PC_RESET};
        foreach (starts[k]) begin
            wait_idle();
            write_program_start(starts[k]);
            repeat (80) send_instr(random_instr());
        end
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        wait_idle();
        src_gaps_on  = 1'b0;
        hold_request = 120;
        repeat (40) send_instr(random_instr());
        src_gaps_on  = 1'b1;
    endtask

    task automatic test_random_mix(input int count);
        int target;
        target = items_sent + count;
        send_call_burst(STACK_DEPTH + 4);
        while (items_sent < target) begin
            if ($urandom_range(0, 29) == 0) send_call_burst($urandom_range(1, STACK_DEPTH + 4));
            else send_instr(random_instr());
        end
    endtask

    // Back-to-back requests with the receiver always ready
    task automatic test_full_rate(input int count);
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        repeat (count) send_instr(random_instr());
    endtask

    // Receiver ready pattern
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready = 1'b0;
            end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 18);
                m_tready   = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin : result_check
        pending_t want;
        result_t  got;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RESULT_W-1:0]);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, m_tdata[15:0], '0);
            end else begin
                want = pending_results.pop_front();
                check_field("next_pc", want.word, 16'(got.next_pc),
                            16'(want.res.next_pc));
                check_field("index_value", want.word, 16'(got.index_value),
                            16'(want.res.index_value));
                check_field("delay_value", want.word, 16'(got.delay_value),
                            16'(want.res.delay_value));
                check_field("sound_value", want.word, 16'(got.sound_value),
                            16'(want.res.sound_value));
                check_field("reg_written", want.word, 16'(got.reg_written),
                            16'(want.res.reg_written));
                check_field("reg_number", want.word, 16'(got.reg_number),
                            16'(want.res.reg_number));
                check_field("reg_value", want.word, 16'(got.reg_value),
                            16'(want.res.reg_value));
                check_field("status", want.word, 16'(got.status), 16'(want.res.status));
                check_field("pad", want.word, 16'(m_tdata[M_TDATA_W-1:RESULT_W]), 16'h0);
            end
        end
    end

    // Timeout
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : run
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        reset_model();
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_values();
        test_program_start();
        test_backpressure();
        test_random_mix(700);
        test_full_rate(200);

        wait_idle();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/c8x_pkg.sv
hdl/c8x_ram.sv
hdl/c8x_core.sv
hdl/chip8_instruction_executor_unit.sv
dv/chip8_instruction_executor_unit_tb.sv
